FILE: hw/rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/pbm_pkg.sv
// ----------------------------------------------------------------------------
// pbm_pkg
// types, mode codes and constants of the pixel blend unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pbm_pkg;
    localparam int unsigned ChanW  = 8;
    localparam int unsigned AmtW   = 9;
    localparam int unsigned ModeW  = 4;
    localparam int unsigned NumColorLanes = 3;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [AmtW-1:0] AmtOne = 9'd256;

    typedef enum logic [ModeW-1:0] {
        MODE_REPLACE    = 4'd0,
        MODE_ADD        = 4'd1,
        MODE_SUBTRACT   = 4'd2,
        MODE_MULTIPLY   = 4'd3,
        MODE_SCREEN     = 4'd4,
        MODE_OVERLAY    = 4'd5,
        MODE_LIGHTEN    = 4'd6,
        MODE_DARKEN     = 4'd7,
        MODE_DODGE      = 4'd8,
        MODE_BURN       = 4'd9,
        MODE_DIFFERENCE = 4'd10
    } t_mode;

    localparam logic [CfgIdxW-1:0] REG_MODE   = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_AMOUNT = 1'd1;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic [ChanW-1:0] alpha;
    } t_pixel;

    typedef struct packed {
        t_pixel src;
        t_pixel dst;
    } t_in_word;

    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [AmtW-1:0]  amount;
    } t_cfg;

    typedef struct packed {
        logic [CfgIdxW-1:0] idx;
        logic [AmtW-1:0]    data;
    } t_cfg_wr;

    // round(x/255) via reciprocal multiply, exact for x < 2^16, may read one high above
    function automatic logic [9:0] div255(input logic [16:0] x);
        logic [17:0] y;
        logic [35:0] p;
        y = {1'b0, x} + 18'd127;
        p = y * 18'd65794;
        return p[33:24];
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/pbm_if.sv
// ----------------------------------------------------------------------------
// pbm_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface pbm_if #(parameter type T = logic [7:0]);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/pbm_lane.sv
// ----------------------------------------------------------------------------
// pbm_lane
// one channel (color or alpha): effect in stage 1, divide and lerp in stage 2/3
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pbm_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic                      i_alpha,
    input  wire pbm_pkg::t_cfg             i_cfg,
    input  wire logic [pbm_pkg::ChanW-1:0] i_s,
    input  wire logic [pbm_pkg::ChanW-1:0] i_d,
    output logic      [pbm_pkg::ChanW-1:0] o_r
);
    import pbm_pkg::*;

    // stage 1: products and selection
    logic [16:0] n_num, r_num;
    logic [7:0]  n_den, r_den;
    logic [1:0]  n_kind, r_kind;
    logic [7:0]  n_e, r_e, r_s;
    logic [8:0]  r_amt;
    logic        r_ovl;
    logic [16:0] n_hnum, r_hnum;
    logic [7:0]  is, id;
    logic [8:0]  amt;

    localparam logic [1:0] K_DIRECT = 2'd0, K_MUL = 2'd1, K_SCR = 2'd2, K_DIV = 2'd3;

    // ceil(2^24 / den), exact quotient for num < 2^16 and den < 256
    typedef logic [255:0][24:0] t_recip_tab;

    function automatic t_recip_tab make_recip_tab();
        t_recip_tab tab;
        tab = '0;
        for (int i = 1; i < 256; i++) begin
            tab[i] = 25'((33'd16777216 + 33'(i) - 33'd1) / 33'(i));
        end
        return tab;
    endfunction

    localparam t_recip_tab RecipTab = make_recip_tab();

    always_comb begin
        is = 8'd255 - i_s;
        id = 8'd255 - i_d;
        amt = (i_cfg.amount > AmtOne) ? AmtOne : i_cfg.amount;
        n_num = '0; n_den = 8'd1; n_kind = K_DIRECT; n_e = i_d; n_hnum = '0;
        if (!i_alpha) begin
            case (t_mode'(i_cfg.mode))
                MODE_ADD:      n_e = ({1'b0, i_s} + {1'b0, i_d} > 9'd255) ? 8'd255 : i_s + i_d;
                MODE_SUBTRACT: n_e = (i_s > i_d) ? i_s - i_d : 8'd0;
                MODE_MULTIPLY: begin
                    n_kind = K_MUL;
                    n_num = {1'b0, 16'(i_s) * 16'(i_d)};
                end
                MODE_SCREEN:   begin
                    n_kind = K_SCR;
                    n_num = {1'b0, 16'(is) * 16'(id)};
                end
                MODE_OVERLAY:  begin
                    n_kind = K_MUL;
                    n_num = {16'(i_s) * 16'(i_d), 1'b0};
                    n_hnum = {16'(is) * 16'(id), 1'b0};
                end
                MODE_LIGHTEN:  n_e = (i_s > i_d) ? i_s : i_d;
                MODE_DARKEN:   n_e = (i_s < i_d) ? i_s : i_d;
                MODE_DODGE:    begin
                    if (i_d == 8'd255) n_e = 8'd255;
                    else begin
                        n_kind = K_DIV; n_den = id;
                        n_num = {1'b0, 16'(i_s) * 16'd255} + 17'(id >> 1);
                        n_e = 8'd0;
                    end
                end
                MODE_BURN:     begin
                    if (i_d == 8'd0) n_e = 8'd0;
                    else begin
                        n_kind = K_DIV; n_den = i_d;
                        n_num = {1'b0, 16'(is) * 16'd255} + 17'(i_d >> 1);
                        n_e = 8'd255;
                    end
                end
                MODE_DIFFERENCE: n_e = (i_s > i_d) ? i_s - i_d : i_d - i_s;
                default:       n_e = i_d;
            endcase
        end else begin
            n_e = i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num <= n_num; r_hnum <= n_hnum; r_den <= n_den; r_kind <= n_kind;
            r_e <= n_e; r_s <= i_s; r_amt <= amt;
            r_ovl <= !i_alpha && (t_mode'(i_cfg.mode) == MODE_OVERLAY);
        end
    end

    // stage 2: quotient by reciprocal table, then effect
    logic [41:0] qp;
    logic [16:0] q;
    logic [9:0]  qm, lo10, k10;
    logic [7:0]  eff, a_v, b_v;
    always_comb begin
        qp = 42'(r_num) * 42'(RecipTab[r_den]);
        q = qp[40:24];
        qm = div255(r_num);
        lo10 = qm;
        k10 = div255(r_hnum);
        eff = r_e;
        case (r_kind)
            K_MUL: eff = qm[7:0];
            K_SCR: eff = 8'd255 - qm[7:0];
            K_DIV: begin
                if (r_e == 8'd255) eff = (q > 17'd255) ? 8'd0 : 8'd255 - q[7:0];
                else eff = (q > 17'd255) ? 8'd255 : q[7:0];
            end
            default: eff = r_e;
        endcase
        a_v = r_s; b_v = eff;
        if (r_ovl) begin
            a_v = (lo10 > 10'd255) ? 8'd255 : lo10[7:0];
            b_v = (k10 > 10'd255) ? 8'd0 : 8'd255 - k10[7:0];
        end
        if (r_amt == 9'd0) begin a_v = r_s; b_v = r_s; end
    end

    logic [7:0] r_a, r_b;
    logic [8:0] r_amt2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin r_a <= a_v; r_b <= b_v; r_amt2 <= r_amt; end
    end

    logic [17:0] mix;
    always_comb begin
        mix = 18'(r_a) * 18'(AmtOne - r_amt2) + 18'(r_b) * 18'(r_amt2) + 18'd128;
        o_r = mix[15:8];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/pixel_blend_mode_unit.sv
// ----------------------------------------------------------------------------
// pixel_blend_mode_unit
// layer blend, unless the output stalls, of one rgba pixel per clock
// ----------------------------------------------------------------------------
// One pixel word per clock; an accepted word passes through the stage-1 and
// stage-2 registers of each lane into the output register. Four channel lanes
// run in parallel, each a three-stage pipeline (effect, divide-by-reciprocal,
// lerp) whose last stage is the shared output register; the whole pipe stalls
// only while the output word waits. Configure only while idle.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pixel_blend_mode_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pbm_if.sink       i_pix,
    pbm_if.sink       i_cfg,
    pbm_if.source     o_pix
);
    import pbm_pkg::*;

    t_cfg r_cfg;
    t_in_word w;
    t_pixel res;
    logic [2:0] r_v;
    logic en;

    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode <= ModeW'(MODE_REPLACE);
            r_cfg.amount <= AmtOne;
        end else if (i_cfg.valid) begin
            if (i_cfg.data.idx == REG_MODE) r_cfg.mode <= i_cfg.data.data[ModeW-1:0];
            else r_cfg.amount <= i_cfg.data.data[AmtW-1:0];
        end
    end

    assign en = !r_v[2] || o_pix.ready;
    assign i_pix.ready = en;
    assign w = i_pix.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[1:0], i_pix.valid};
    end

    pbm_lane u_r (.i_clk, .i_en(en), .i_alpha(1'b0), .i_cfg(r_cfg),
                  .i_s(w.src.red), .i_d(w.dst.red), .o_r(res.red));
    pbm_lane u_g (.i_clk, .i_en(en), .i_alpha(1'b0), .i_cfg(r_cfg),
                  .i_s(w.src.green), .i_d(w.dst.green), .o_r(res.green));
    pbm_lane u_b (.i_clk, .i_en(en), .i_alpha(1'b0), .i_cfg(r_cfg),
                  .i_s(w.src.blue), .i_d(w.dst.blue), .o_r(res.blue));
    pbm_lane u_a (.i_clk, .i_en(en), .i_alpha(1'b1), .i_cfg(r_cfg),
                  .i_s(w.src.alpha), .i_d(w.dst.alpha), .o_r(res.alpha));

    // merge lanes into the output register
    t_pixel r_out;
    always_ff @(posedge i_clk) begin
        if (en) r_out <= res;
    end
    assign o_pix.valid = r_v[2];
    assign o_pix.data = r_out;

    `ASSERT_IMPL(a_stall_holds, i_clk, i_rst_n, o_pix.valid && !o_pix.ready, !i_pix.ready)
    `ASSERT_NEXT(a_out_keeps, i_clk, i_rst_n, o_pix.valid && !o_pix.ready, o_pix.valid)
endmodule
`default_nettype wire
